[rtl/msph_pkg.sv]
`timescale 1ns / 1ps

package msph_pkg;

  // Default coordinate width (two's complement, Q16.16)
  localparam int COORD_WIDTH_DEF = 32;

  // Time format: unsigned Q32.16, saturating
  localparam int TIME_W      = 48;
  localparam int TIME_FRAC_W = 16;
  localparam int TIME_INT_W  = TIME_W - TIME_FRAC_W;

  // Configuration register map
  localparam int NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_VELOCITY_X = 3'd3,
    REG_VELOCITY_Y = 3'd4,
    REG_VELOCITY_Z = 3'd5,
    REG_RADIUS     = 3'd6
  } reg_idx_t;

endpackage

[rtl/msph_mul.sv]
`timescale 1ns / 1ps

// Two-stage signed multiplier: four half-width partial products, then their sum
module msph_mul #(
  parameter int AW = 66,
  parameter int BW = 66
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int BL = BW / 2;
  localparam int PW = AW + BW;

  logic signed [AW-AL-1:0]          a_hi;
  logic signed [AL:0]               a_lo;
  logic signed [BW-BL-1:0]          b_hi;
  logic signed [BL:0]               b_lo;
  logic signed [AW-AL+BW-BL-1:0]    hh;
  logic signed [AW-AL+BL:0]         hl;
  logic signed [AL+BW-BL:0]         lh;
  logic signed [AL+BL+1:0]          ll;

  // Split each operand into a signed upper half and an unsigned lower half
  assign a_hi = a[AW-1:AL];
  assign a_lo = {1'b0, a[AL-1:0]};
  assign b_hi = b[BW-1:BL];
  assign b_lo = {1'b0, b[BL-1:0]};

  // Register the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= a_hi * b_hi;
      hl <= a_hi * b_lo;
      lh <= a_lo * b_hi;
      ll <= a_lo * b_lo;
    end
  end

  // Weight and add the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(hh) <<< (AL + BL)) + (PW'(hl) <<< AL) + (PW'(lh) <<< BL) + PW'(ll);
    end
  end

endmodule

[rtl/msph_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined floor square root, one root bit per stage
module msph_sqrt #(
  parameter int DW  = 132,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  logic [DW-1:0]     rad_in,
  input  logic [SBW-1:0]    sb_in,
  output logic              vld_out,
  output logic [DW/2-1:0]   root_out,
  output logic [SBW-1:0]    sb_out
);

  localparam int SW = DW / 2;

  logic            vld  [0:SW-1];
  logic [SW+1:0]   rem  [0:SW-1];
  logic [SW-1:0]   root [0:SW-1];
  logic [DW-1:0]   rad  [0:SW-1];
  logic [SBW-1:0]  sb   [0:SW-1];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic            src_vld;
    logic [SW+1:0]   src_rem;
    logic [SW-1:0]   src_root;
    logic [DW-1:0]   src_rad;
    logic [SBW-1:0]  src_sb;
    logic [SW+1:0]   cur;
    logic [SW+1:0]   trial;

    // Take the request from the port or from the stage before
    if (j == 0) begin : g_first
      assign src_vld  = vld_in;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = rad_in;
      assign src_sb   = sb_in;
    end else begin : g_next
      assign src_vld  = vld[j-1];
      assign src_rem  = rem[j-1];
      assign src_root = root[j-1];
      assign src_rad  = rad[j-1];
      assign src_sb   = sb[j-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign cur   = {src_rem[SW-1:0], src_rad[DW-1:DW-2]};
    assign trial = {src_root, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[j] <= src_rad << 2;
        sb[j]  <= src_sb;
        if (cur >= trial) begin
          rem[j]  <= cur - trial;
          root[j] <= {src_root[SW-2:0], 1'b1};
        end else begin
          rem[j]  <= cur;
          root[j] <= {src_root[SW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_out  = vld[SW-1];
  assign root_out = root[SW-1];
  assign sb_out   = sb[SW-1];

endmodule

[rtl/msph_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider: floor(num * 2^16 / den) for two numerators over one
// divisor, one quotient bit per stage, saturating at the time range
module msph_div #(
  parameter int DENW = 64,
  parameter int NW   = 66,
  parameter int SBW  = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [NW-1:0]                num_a,
  input  logic [NW-1:0]                num_b,
  input  logic [DENW-1:0]              den,
  input  logic [SBW-1:0]               sb_in,
  output logic                         vld_out,
  output logic [msph_pkg::TIME_W-1:0]  q_a,
  output logic [msph_pkg::TIME_W-1:0]  q_b,
  output logic [SBW-1:0]               sb_out
);

  localparam int ST   = msph_pkg::TIME_W;
  localparam int IW   = msph_pkg::TIME_INT_W;
  localparam int FRW  = msph_pkg::TIME_FRAC_W;
  localparam int RW   = DENW + 1;
  localparam int CMPW = DENW + IW;

  logic            vld   [0:ST];
  logic            sat_a [0:ST];
  logic            sat_b [0:ST];
  logic [RW-1:0]   rem_a [0:ST];
  logic [RW-1:0]   rem_b [0:ST];
  logic [ST-1:0]   qa    [0:ST];
  logic [ST-1:0]   qb    [0:ST];
  logic [IW-1:0]   low_a [0:ST];
  logic [IW-1:0]   low_b [0:ST];
  logic [DENW-1:0] dv    [0:ST];
  logic [SBW-1:0]  sb    [0:ST];

  // Shift in one dividend bit, subtract the divisor where it fits
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic bit_in,
                                           input logic [DENW-1:0] d);
    logic [RW-1:0] sh;
    sh = {rem[RW-2:0], bit_in};
    if (sh >= RW'(d)) begin
      div_step = {sh - RW'(d), 1'b1};
    end else begin
      div_step = {sh, 1'b0};
    end
  endfunction

  // Check for saturation and load the upper numerator bits as first remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_a[0] <= CMPW'(num_a) >= {den, {IW{1'b0}}};
      sat_b[0] <= CMPW'(num_b) >= {den, {IW{1'b0}}};
      rem_a[0] <= RW'(num_a[NW-1:IW]);
      rem_b[0] <= RW'(num_b[NW-1:IW]);
      low_a[0] <= num_a[IW-1:0];
      low_b[0] <= num_b[IW-1:0];
      qa[0]    <= '0;
      qb[0]    <= '0;
      dv[0]    <= den;
      sb[0]    <= sb_in;
    end
  end

  for (genvar s = 1; s <= ST; s++) begin : g_stage
    localparam int K = ST - s;
    logic        bit_a;
    logic        bit_b;
    logic [RW:0] step_a;
    logic [RW:0] step_b;

    // Dividend bits below the fraction point are zero
    if (K >= FRW) begin : g_num_bit
      assign bit_a = low_a[s-1][K-FRW];
      assign bit_b = low_b[s-1][K-FRW];
    end else begin : g_zero_bit
      assign bit_a = 1'b0;
      assign bit_b = 1'b0;
    end

    assign step_a = div_step(rem_a[s-1], bit_a, dv[s-1]);
    assign step_b = div_step(rem_b[s-1], bit_b, dv[s-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s] <= step_a[RW:1];
        rem_b[s] <= step_b[RW:1];
        qa[s]    <= {qa[s-1][ST-2:0], step_a[0]};
        qb[s]    <= {qb[s-1][ST-2:0], step_b[0]};
        sat_a[s] <= sat_a[s-1];
        sat_b[s] <= sat_b[s-1];
        low_a[s] <= low_a[s-1];
        low_b[s] <= low_b[s-1];
        dv[s]    <= dv[s-1];
        sb[s]    <= sb[s-1];
      end
    end
  end

  assign vld_out = vld[ST];
  assign q_a     = sat_a[ST] ? {ST{1'b1}} : qa[ST];
  assign q_b     = sat_b[ST] ? {ST{1'b1}} : qb[ST];
  assign sb_out  = sb[ST];

endmodule

[rtl/moving_sphere_point_hit_interval.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------
// s_*      | in        | s_tvalid / s_tready     | s_tdata: point_x, point_y, point_z
// m_*      | out       | m_tvalid / m_tready     | m_tdata: collides, hit_from, hit_to,
//          |           |                         |          hit_to_unbounded
// APB      | in/out    | psel, penable, pready   | 7 registers, centre, velocity, radius
//
// One request enters per clock while the output is not stalled; the pipeline depth is set
// by the square root (one root bit per stage) and the divider (one quotient bit per stage,
// 48 stages).
// Reset (rst, synchronous) clears the valid bits and zeroes the configuration registers.
// All stages advance together whenever the output register is empty or being taken,
// so a stall holds every request in place.
module moving_sphere_point_hit_interval #(
  parameter int COORD_WIDTH = msph_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,

  // Query points
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // point_x, point_y, point_z from bit 0 up, zero padded to whole bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,

  // Hit intervals
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // collides, hit_from, hit_to, hit_to_unbounded from bit 0 up, zero padded
  output logic [((2*msph_pkg::TIME_W+2+7)/8)*8-1:0] m_tdata,

  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [$clog2(msph_pkg::NUM_REGS*((COORD_WIDTH>32)?8:4))-1:0] paddr,
  input  logic [((COORD_WIDTH>32)?64:32)-1:0]   pwdata,
  output logic [((COORD_WIDTH>32)?64:32)-1:0]   prdata,
  output logic                                  pready
);

  localparam int W     = COORD_WIDTH;
  localparam int TW    = msph_pkg::TIME_W;
  localparam int PDW   = (W > 32) ? 64 : 32;
  localparam int PAW   = $clog2(msph_pkg::NUM_REGS * (PDW / 8));
  localparam int SH    = $clog2(PDW / 8);
  localparam int OUT_W = ((2 * TW + 2 + 7) / 8) * 8;
  localparam int FW    = W + 1;
  localparam int AW    = 2 * W;
  localparam int BW    = 2 * W + 2;
  localparam int CW    = 2 * W + 3;
  localparam int DW    = 4 * W + 4;
  localparam int SW    = DW / 2;
  localparam int LW    = 2 * W + 3;
  localparam int NW    = 2 * W + 2;

  typedef struct packed {
    logic                 azero;
    logic                 chit;
    logic                 dneg;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
  } sq_side_t;

  typedef struct packed {
    logic azero;
    logic chit;
    logic dneg;
    logic loneg;
    logic hineg;
  } hit_flags_t;

  logic en;

  // Configuration registers
  logic [W-1:0]   cx, cy, cz, vx, vy, vz;
  logic [W-2:0]   rad;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  // Pipeline registers
  logic                   vld1, vld2, vld3, vld4, vld5, vld6, vld7;
  logic signed [FW-1:0]   fx, fy, fz;
  logic signed [2*W:0]    fvx, fvy, fvz;
  logic signed [2*W+1:0]  ffx, ffy, ffz;
  logic signed [2*W-1:0]  vvx, vvy, vvz;
  logic [2*W-3:0]         rr;
  logic [AW-1:0]          a3, a4, a5;
  logic signed [BW-1:0]   b3, b4, b5;
  logic signed [CW-1:0]   c3;
  logic                   chit4, chit5;
  logic signed [DW-1:0]   bb, ac, d6;
  sq_side_t               sq_in, sq_out;
  logic                   sq_vld;
  logic [SW-1:0]          root;
  logic signed [LW-1:0]   lo7, hi7;
  logic [AW-1:0]          a7;
  hit_flags_t             fl7, fl_out;
  logic                   dv_vld;
  logic [TW-1:0]          q_lo, q_hi;
  logic                   o_collides, o_unb;
  logic [TW-1:0]          o_from, o_to;

  // Advance the whole pipeline unless a finished request is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pready   = 1'b1;

  // Register write and read decode
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PAW-1:SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      cz  <= '0;
      vx  <= '0;
      vy  <= '0;
      vz  <= '0;
      rad <= '0;
    end else if (cfg_wr) begin
      case (msph_pkg::reg_idx_t'(cfg_idx))
        msph_pkg::REG_CENTER_X:   cx  <= pwdata[W-1:0];
        msph_pkg::REG_CENTER_Y:   cy  <= pwdata[W-1:0];
        msph_pkg::REG_CENTER_Z:   cz  <= pwdata[W-1:0];
        msph_pkg::REG_VELOCITY_X: vx  <= pwdata[W-1:0];
        msph_pkg::REG_VELOCITY_Y: vy  <= pwdata[W-1:0];
        msph_pkg::REG_VELOCITY_Z: vz  <= pwdata[W-1:0];
        msph_pkg::REG_RADIUS:     rad <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (msph_pkg::reg_idx_t'(cfg_idx))
      msph_pkg::REG_CENTER_X:   prdata = PDW'(cx);
      msph_pkg::REG_CENTER_Y:   prdata = PDW'(cy);
      msph_pkg::REG_CENTER_Z:   prdata = PDW'(cz);
      msph_pkg::REG_VELOCITY_X: prdata = PDW'(vx);
      msph_pkg::REG_VELOCITY_Y: prdata = PDW'(vy);
      msph_pkg::REG_VELOCITY_Z: prdata = PDW'(vz);
      msph_pkg::REG_RADIUS:     prdata = PDW'(rad);
      default:                  prdata = '0;
    endcase
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
      vld7 <= 1'b0;
    end else if (en) begin
      vld1 <= s_tvalid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
      vld6 <= vld5;
      vld7 <= sq_vld;
    end
  end

  // Offset of the point from the centre, products, and the three coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      fx  <= FW'($signed(s_tdata[W-1:0]))     - FW'($signed(cx));
      fy  <= FW'($signed(s_tdata[2*W-1:W]))   - FW'($signed(cy));
      fz  <= FW'($signed(s_tdata[3*W-1:2*W])) - FW'($signed(cz));

      fvx <= fx * $signed(vx);
      fvy <= fy * $signed(vy);
      fvz <= fz * $signed(vz);
      ffx <= fx * fx;
      ffy <= fy * fy;
      ffz <= fz * fz;
      vvx <= $signed(vx) * $signed(vx);
      vvy <= $signed(vy) * $signed(vy);
      vvz <= $signed(vz) * $signed(vz);
      rr  <= rad * rad;

      a3  <= AW'($unsigned(vvx)) + AW'($unsigned(vvy)) + AW'($unsigned(vvz));
      b3  <= BW'(fvx) + BW'(fvy) + BW'(fvz);
      c3  <= CW'(ffx) + CW'(ffy) + CW'(ffz) - $signed(CW'(rr));
    end
  end

  // B squared and A times C
  msph_mul #(.AW(BW), .BW(BW)) u_mul_bb (
    .clk (clk),
    .en  (en),
    .a   (b3),
    .b   (b3),
    .p   (bb)
  );

  msph_mul #(.AW(AW + 1), .BW(CW)) u_mul_ac (
    .clk (clk),
    .en  (en),
    .a   ($signed({1'b0, a3})),
    .b   (c3),
    .p   (ac)
  );

  // Carry A, B and the inside flag alongside the multipliers, then form the discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      a4          <= a3;
      b4          <= b3;
      chit4       <= c3[CW-1];
      a5          <= a4;
      b5          <= b4;
      chit5       <= chit4;
      d6          <= bb - ac;
      sq_in.azero <= (a5 == '0);
      sq_in.chit  <= chit5;
      sq_in.dneg  <= (bb - ac) < 0;
      sq_in.a     <= a5;
      sq_in.b     <= b5;
    end
  end

  msph_sqrt #(.DW(DW), .SBW($bits(sq_side_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld6),
    .rad_in   (d6),
    .sb_in    (sq_in),
    .vld_out  (sq_vld),
    .root_out (root),
    .sb_out   (sq_out)
  );

  // Numerators of the two roots
  always_ff @(posedge clk) begin
    if (en) begin
      lo7       <= LW'(sq_out.b) - $signed(LW'(root));
      hi7       <= LW'(sq_out.b) + $signed(LW'(root));
      a7        <= sq_out.a;
      fl7.azero <= sq_out.azero;
      fl7.chit  <= sq_out.chit;
      fl7.dneg  <= sq_out.dneg;
      fl7.loneg <= 1'b0;
      fl7.hineg <= 1'b0;
    end
  end

  msph_div #(.DENW(AW), .NW(NW), .SBW($bits(hit_flags_t))) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vld7),
    .num_a   (lo7[NW-1:0]),
    .num_b   (hi7[NW-1:0]),
    .den     (a7),
    .sb_in   ({fl7.azero, fl7.chit, fl7.dneg, lo7[LW-1], hi7[LW-1]}),
    .vld_out (dv_vld),
    .q_a     (q_lo),
    .q_b     (q_hi),
    .sb_out  (fl_out)
  );

  // Select the result: static sphere, miss, or the clamped interval
  always_comb begin
    o_unb = fl_out.azero && fl_out.chit;
    if (fl_out.azero) begin
      o_collides = fl_out.chit;
      o_from     = '0;
      o_to       = fl_out.chit ? {TW{1'b1}} : '0;
    end else if (fl_out.dneg || fl_out.hineg) begin
      o_collides = 1'b0;
      o_from     = '0;
      o_to       = '0;
    end else begin
      o_collides = 1'b1;
      o_from     = fl_out.loneg ? '0 : q_lo;
      o_to       = q_hi;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({o_unb, o_to, o_from, o_collides});
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CW      = 32;
  localparam int SDW     = ((3*CW+7)/8)*8;
  localparam int MDW     = ((2*msph_pkg::TIME_W+2+7)/8)*8;
  localparam int AW      = $clog2(msph_pkg::NUM_REGS*4);
  localparam int LATENCY = 2*CW + 59;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam logic [msph_pkg::TIME_W-1:0] TIME_SAT = '1;

  typedef struct packed {
    logic                        unbounded;
    logic [msph_pkg::TIME_W-1:0] t_to;
    logic [msph_pkg::TIME_W-1:0] t_from;
    logic                        hit;
  } interval_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [SDW-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [MDW-1:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  // Shadow copy of the sphere registers
  logic signed [CW-1:0] sph_c [3];
  logic signed [CW-1:0] sph_v [3];
  logic [CW-2:0]        sph_r;

  interval_t expected_hits [$];
  int  errors;
  int  send_gap_pct, recv_gap_pct;
  bit  recv_hold;
  longint unsigned cycles;

  moving_sphere_point_hit_interval #(.COORD_WIDTH(CW)) dut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Floor square root of a nonnegative 256-bit value
  function automatic logic [255:0] isqrt256(logic [255:0] n);
    logic [255:0] root, bit_w, trial;
    root  = '0;
    bit_w = 256'd1 << 254;
    for (int k = 0; k < 128; k++) begin
      trial = root + bit_w;
      if (n >= trial) begin
        n    = n - trial;
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Q32.16 time num/den, saturated
  function automatic logic [msph_pkg::TIME_W-1:0] time_of(logic [255:0] num,
                                                          logic [255:0] den);
    logic [271:0] q;
    q = ({num, 16'd0}) / {16'd0, den};
    if (q > {224'd0, TIME_SAT}) return TIME_SAT;
    return q[msph_pkg::TIME_W-1:0];
  endfunction

  function automatic interval_t cover_interval(logic signed [CW-1:0] p [3]);
    logic signed [255:0] a, b, c, d, f, v, root, lo, hi;
    interval_t res;
    a = 0; b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      f = 256'(signed'(p[i])) - 256'(signed'(sph_c[i]));
      v = 256'(signed'(sph_v[i]));
      a += v * v;
      b += f * v;
      c += f * f;
    end
    c -= 256'(sph_r) * 256'(sph_r);
    res = '0;
    if (a == 0) begin
      // Static sphere: strictly inside only
      if (c < 0) begin
        res.hit = 1'b1;
        res.t_to = TIME_SAT;
        res.unbounded = 1'b1;
      end
      return res;
    end
    d = b * b - a * c;
    if (d < 0) return res;
    root = isqrt256(d);
    lo = b - root;
    hi = b + root;
    if (hi < 0) return res;
    res.hit = 1'b1;
    res.t_from = (lo < 0) ? '0 : time_of(lo, a);
    res.t_to = time_of(hi, a);
    return res;
  endfunction

  task automatic write_reg(msph_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      msph_pkg::REG_CENTER_X, msph_pkg::REG_CENTER_Y, msph_pkg::REG_CENTER_Z:
        sph_c[int'(idx)] = value;
      msph_pkg::REG_VELOCITY_X, msph_pkg::REG_VELOCITY_Y, msph_pkg::REG_VELOCITY_Z:
        sph_v[int'(idx) - 3] = value;
      default: sph_r = value[CW-2:0];
    endcase
  endtask

  task automatic set_sphere(logic [31:0] cx, cy, cz, vx, vy, vz, r);
    write_reg(msph_pkg::REG_CENTER_X, cx);   write_reg(msph_pkg::REG_CENTER_Y, cy);
    write_reg(msph_pkg::REG_CENTER_Z, cz);   write_reg(msph_pkg::REG_VELOCITY_X, vx);
    write_reg(msph_pkg::REG_VELOCITY_Y, vy); write_reg(msph_pkg::REG_VELOCITY_Z, vz);
    write_reg(msph_pkg::REG_RADIUS, r);
  endtask

  // Offer one request and hold it until taken
  task automatic send_point(logic [31:0] px, py, pz);
    logic signed [CW-1:0] p [3];
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    p[0] = px; p[1] = py; p[2] = pz;
    s_tvalid <= 1'b1;
    s_tdata  <= {px, py, pz} == 0 ? '0 : {pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_hits.push_back(cover_interval(p));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    // Static sphere: centre, boundary, inside, extremes
    set_sphere(0, 0, 0, 0, 0, 0, 32'h0001_0000);
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 0, 0);
    send_point(32'h0000_8000, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    // Moving sphere: tangent touch, approaching, passed, inside now, miss
    set_sphere(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_point(32'h0005_0000, 0, 0);
    send_point(32'h0005_0000, 32'h0001_0000, 0);
    send_point(32'hFFFB_0000, 32'h0001_0000, 0);
    send_point(0, 32'h0001_0000, 0);
    send_point(32'h0005_0000, 32'h0003_0000, 0);
    drain();
    // Extreme registers: saturation of the times, largest radius
    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(0, 0, 0);
    drain();
    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        drain();
        set_sphere(rand_coord(), rand_coord(), rand_coord(),
                   ($urandom_range(3) == 0) ? 0 : rand_coord(),
                   ($urandom_range(3) == 0) ? 0 : rand_coord(),
                   ($urandom_range(3) == 0) ? 0 : rand_coord(),
                   $urandom_range(2) == 0 ? $urandom & 32'h7FFF_FFFF
                                          : $urandom_range(32'h0010_0000));
      end
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_backpressure;
    drain();
    set_sphere(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0002_0000);
    recv_hold = 1'b1;
    // Hold the receiver off for a long stretch in its own process
    fork
      begin
        repeat (3*LATENCY) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    for (int k = 0; k < 2*LATENCY; k++) send_point(rand_coord(), rand_coord(), 0);
    drain();
  endtask

  // Receiver side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !recv_hold && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    interval_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(interval_t)-1:0];
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (got.hit !== want.hit)
          $display("%0t: collides exp %b got %b", $time, want.hit, got.hit);
        if (got.t_from !== want.t_from)
          $display("%0t: hit_from exp %h got %h", $time, want.t_from, got.t_from);
        if (got.t_to !== want.t_to)
          $display("%0t: hit_to exp %h got %h", $time, want.t_to, got.t_to);
        if (got.unbounded !== want.unbounded)
          $display("%0t: unbounded exp %b got %b", $time, want.unbounded, got.unbounded);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0; cycles = 0; recv_hold = 1'b0;
    send_gap_pct = 8; recv_gap_pct = 77;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 3; i++) begin
      sph_c[i] = '0; sph_v[i] = '0;
    end
    sph_r = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(96);
    drain();
    send_gap_pct = 77; recv_gap_pct = 8;
    test_random(96);
    drain();
    send_gap_pct = 0; recv_gap_pct = 0;
    test_random(96);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/msph_pkg.sv
rtl/msph_mul.sv
rtl/msph_sqrt.sv
rtl/msph_div.sv
rtl/moving_sphere_point_hit_interval.sv
verif/tb_top.sv
